/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the warp address core.
// Needs nothing else; checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

/* rtl/mpw_pkg.sv */
// Constants, register indexes and pipeline types of the warp address core.
// Depends on nothing; used by every other file but assert_macros.svh.
`timescale 1ns / 1ps
package mpw_pkg;
  localparam int NUM_VERTICES = 4;
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS = 20;
  localparam int COEF_W = 32;
  localparam int CFG_W = 64;
  localparam int IDX_W = 3;
  localparam int DIM_W = 13;
  localparam int PROD_W = COEF_W + COORD_BITS + 1;
  localparam int SUM_W = PROD_W + 2;
  localparam int NUM_W = SUM_W + 2;
  localparam int REM_W = NUM_W + COORD_BITS;
  localparam int EDGE_W = 2 * (COORD_BITS + 1);

  localparam logic [IDX_W-1:0] REG_COEF_XX_XY = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_XC_YX = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_YY_YC = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_WX_WY = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_WC = 3'd4;
  localparam logic [IDX_W-1:0] REG_VERTEX_01 = 3'd5;
  localparam logic [IDX_W-1:0] REG_VERTEX_23 = 3'd6;
  localparam logic [IDX_W-1:0] REG_IMAGE_SIZE = 3'd7;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_BITS;
  localparam logic [2*DIM_W-1:0] IMAGE_SIZE_RESET = 26'd3932800;

  typedef struct packed {
    logic [8:0][COEF_W-1:0] m;
    logic [NUM_VERTICES-1:0][COORD_BITS-1:0] vx;
    logic [NUM_VERTICES-1:0][COORD_BITS-1:0] vy;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic keep;
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [REM_W-1:0] dsh;
    logic [COORD_BITS-1:0] q_x;
    logic [COORD_BITS-1:0] q_y;
  } div_t;
endpackage

/* rtl/mpw_coord_if.sv */
// Handshake channel for destination coordinates.
// Depends on mpw_pkg.
`timescale 1ns / 1ps
interface mpw_coord_if;
  logic valid;
  logic ready;
  logic [mpw_pkg::COORD_BITS-1:0] dest_x;
  logic [mpw_pkg::COORD_BITS-1:0] dest_y;
  modport source (output valid, output dest_x, output dest_y, input ready);
  modport sink (input valid, input dest_x, input dest_y, output ready);
endinterface

/* rtl/mpw_result_if.sv */
// Handshake channel for source addresses with write enable.
// Depends on mpw_pkg.
`timescale 1ns / 1ps
interface mpw_result_if;
  logic valid;
  logic ready;
  logic [mpw_pkg::COORD_BITS-1:0] src_x;
  logic [mpw_pkg::COORD_BITS-1:0] src_y;
  logic write_enable;
  modport source (output valid, output src_x, output src_y, output write_enable, input ready);
  modport sink (input valid, input src_x, input src_y, input write_enable, output ready);
endinterface

/* rtl/mpw_cfg_if.sv */
// Register write channel: index and data.
// Depends on mpw_pkg.
`timescale 1ns / 1ps
interface mpw_cfg_if;
  logic valid;
  logic ready;
  logic [mpw_pkg::IDX_W-1:0] index;
  logic [mpw_pkg::CFG_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/mpw_transform.sv */
// Three-stage front end: matrix products, sums and polygon test, divider set-up.
// Depends on mpw_pkg.
`timescale 1ns / 1ps
module mpw_transform (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic [mpw_pkg::COORD_BITS-1:0] dest_x,
  input  logic [mpw_pkg::COORD_BITS-1:0] dest_y,
  input  mpw_pkg::cfg_t cfg,
  output mpw_pkg::div_t div_out
);
  localparam int NV = mpw_pkg::NUM_VERTICES;
  localparam int CB = mpw_pkg::COORD_BITS;
  localparam int PW = mpw_pkg::PROD_W;
  localparam int SW = mpw_pkg::SUM_W;
  localparam int NW = mpw_pkg::NUM_W;
  localparam int RW = mpw_pkg::REM_W;
  localparam int EW = mpw_pkg::EDGE_W;

  // stage 1
  logic s1_valid;
  logic signed [PW-1:0] s1_p [6];
  logic signed [mpw_pkg::COEF_W-1:0] s1_c02, s1_c12, s1_c22;
  logic [NV-1:0] s1_cross, s1_dpos;
  logic signed [EW-1:0] s1_lhs [NV];
  logic signed [EW-1:0] s1_rhs [NV];
  // stage 2
  logic s2_valid, s2_inside;
  logic signed [SW-1:0] s2_xp, s2_yp, s2_wp;

  logic signed [CB:0] sx, sy;
  logic signed [PW-1:0] p_next [6];
  logic [NV-1:0] cross_next, dpos_next, left;
  logic signed [EW-1:0] lhs_next [NV];
  logic signed [EW-1:0] rhs_next [NV];
  logic inside_next;

  always_comb begin
    sx = $signed({1'b0, dest_x});
    sy = $signed({1'b0, dest_y});
    p_next[0] = PW'($signed(cfg.m[0])) * PW'(sx);
    p_next[1] = PW'($signed(cfg.m[1])) * PW'(sy);
    p_next[2] = PW'($signed(cfg.m[3])) * PW'(sx);
    p_next[3] = PW'($signed(cfg.m[4])) * PW'(sy);
    p_next[4] = PW'($signed(cfg.m[6])) * PW'(sx);
    p_next[5] = PW'($signed(cfg.m[7])) * PW'(sy);
  end

  for (genvar i = 0; i < NV; i++) begin : g_edge
    localparam int J = (i == 0) ? NV - 1 : i - 1;
    logic signed [CB:0] xi, yi, xj, yj, d, dx, ex, ey;
    always_comb begin
      xi = $signed({1'b0, cfg.vx[i]});
      yi = $signed({1'b0, cfg.vy[i]});
      xj = $signed({1'b0, cfg.vx[J]});
      yj = $signed({1'b0, cfg.vy[J]});
      d = yj - yi;
      dx = sx - xi;
      ex = xj - xi;
      ey = sy - yi;
      cross_next[i] = (cfg.vy[i] > dest_y) != (cfg.vy[J] > dest_y);
      dpos_next[i] = (d > 0);
      lhs_next[i] = EW'(dx) * EW'(d);
      rhs_next[i] = EW'(ex) * EW'(ey);
      left[i] = s1_cross[i] &&
                (s1_dpos[i] ? (s1_lhs[i] < s1_rhs[i]) : (s1_lhs[i] > s1_rhs[i]));
    end
  end

  always_comb begin
    inside_next = 1'b0;
    for (int k = 0; k < NV; k++) begin
      inside_next = inside_next ^ left[k];
    end
  end

  // stage 3 set-up
  logic signed [NW-1:0] num_x, num_y, den;
  logic [NW-1:0] mag_x, mag_y, mag_d;
  logic same_x, same_y, ok_x, ok_y;
  logic [RW-1:0] lim;
  mpw_pkg::div_t div_next;

  always_comb begin
    num_x = (NW'(s2_xp) <<< 1) + NW'(s2_wp);
    num_y = (NW'(s2_yp) <<< 1) + NW'(s2_wp);
    den = NW'(s2_wp) <<< 1;
    mag_x = num_x[NW-1] ? NW'(-num_x) : NW'(num_x);
    mag_y = num_y[NW-1] ? NW'(-num_y) : NW'(num_y);
    mag_d = den[NW-1] ? NW'(-den) : NW'(den);
    same_x = num_x[NW-1] == den[NW-1];
    same_y = num_y[NW-1] == den[NW-1];
    lim = RW'(mag_d) << CB;
    ok_x = same_x ? (RW'(mag_x) < lim) : (mag_x < mag_d);
    ok_y = same_y ? (RW'(mag_y) < lim) : (mag_y < mag_d);
    div_next.valid = s2_valid;
    div_next.keep = s2_inside && (s2_wp != '0) && ok_x && ok_y;
    div_next.rem_x = same_x ? RW'(mag_x) : '0;
    div_next.rem_y = same_y ? RW'(mag_y) : '0;
    div_next.dsh = RW'(mag_d) << (CB - 1);
    div_next.q_x = '0;
    div_next.q_y = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      div_out.valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      div_out.valid <= div_next.valid;
    end
    if (adv) begin
      s1_p <= p_next;
      s1_c02 <= $signed(cfg.m[2]);
      s1_c12 <= $signed(cfg.m[5]);
      s1_c22 <= $signed(cfg.m[8]);
      s1_cross <= cross_next;
      s1_dpos <= dpos_next;
      s1_lhs <= lhs_next;
      s1_rhs <= rhs_next;
      s2_xp <= SW'(s1_p[0]) + SW'(s1_p[1]) + SW'(s1_c02);
      s2_yp <= SW'(s1_p[2]) + SW'(s1_p[3]) + SW'(s1_c12);
      s2_wp <= SW'(s1_p[4]) + SW'(s1_p[5]) + SW'(s1_c22);
      s2_inside <= inside_next;
      div_out.keep <= div_next.keep;
      div_out.rem_x <= div_next.rem_x;
      div_out.rem_y <= div_next.rem_y;
      div_out.dsh <= div_next.dsh;
      div_out.q_x <= div_next.q_x;
      div_out.q_y <= div_next.q_y;
    end
  end
endmodule

/* rtl/mpw_div_step.sv */
// One restoring division step for both coordinate lanes, registered.
// Depends on mpw_pkg.
`timescale 1ns / 1ps
module mpw_div_step (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  mpw_pkg::div_t d_in,
  output mpw_pkg::div_t d_out
);
  localparam int RW = mpw_pkg::REM_W;
  localparam int CB = mpw_pkg::COORD_BITS;
  logic ge_x, ge_y;
  logic [RW-1:0] r_x, r_y;

  always_comb begin
    ge_x = d_in.rem_x >= d_in.dsh;
    ge_y = d_in.rem_y >= d_in.dsh;
    r_x = ge_x ? d_in.rem_x - d_in.dsh : d_in.rem_x;
    r_y = ge_y ? d_in.rem_y - d_in.dsh : d_in.rem_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (adv) begin
      d_out.valid <= d_in.valid;
    end
    if (adv) begin
      d_out.keep <= d_in.keep;
      d_out.dsh <= d_in.dsh;
      d_out.rem_x <= r_x << 1;
      d_out.rem_y <= r_y << 1;
      d_out.q_x <= {d_in.q_x[CB-2:0], ge_x};
      d_out.q_y <= {d_in.q_y[CB-2:0], ge_y};
    end
  end
endmodule

/* rtl/masked_projective_warp_address.sv */
// Top level of the warp address core: registers, pipeline and result stage.
// Depends on mpw_pkg, the channel interfaces, mpw_transform, mpw_div_step and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Maps each destination pixel through a 3x3 projective matrix, rounds x/w and
// y/w to the nearest source pixel (halves away from minus infinity, truncated
// toward zero) and flags the write when the pixel is inside the configured
// quadrilateral and the source lies in the image. One transaction enters per
// cycle unless the pipeline holds; each passes through three front-end stages
// (products, sums with the polygon test, divider set-up), one restoring
// division step per result bit (12 stages) and the result register. The whole
// pipeline holds while a result waits to be taken. Write registers only while
// the pipeline is empty.
module masked_projective_warp_address_core (
  input logic clk,
  input logic rst,
  mpw_coord_if.sink coord,
  mpw_result_if.source result,
  mpw_cfg_if.sink cfg
);
  localparam int CB = mpw_pkg::COORD_BITS;
  localparam int NV = mpw_pkg::NUM_VERTICES;
  localparam int DW = mpw_pkg::DIM_W;

  logic [mpw_pkg::CFG_W-1:0] coef_xx_xy, coef_xc_yx, coef_yy_yc, coef_wx_wy;
  logic [mpw_pkg::COEF_W-1:0] coef_wc;
  logic [47:0] vertex_pair_01, vertex_pair_23;
  logic [2*DW-1:0] image_size;
  mpw_pkg::cfg_t cfg_bus;
  logic adv;
  mpw_pkg::div_t chain [CB+1];
  logic we_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_xx_xy <= {32'd0, mpw_pkg::COEF_ONE};
      coef_xc_yx <= '0;
      coef_yy_yc <= {32'd0, mpw_pkg::COEF_ONE};
      coef_wx_wy <= '0;
      coef_wc <= mpw_pkg::COEF_ONE;
      vertex_pair_01 <= '0;
      vertex_pair_23 <= '0;
      image_size <= mpw_pkg::IMAGE_SIZE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        mpw_pkg::REG_COEF_XX_XY: coef_xx_xy <= cfg.data;
        mpw_pkg::REG_COEF_XC_YX: coef_xc_yx <= cfg.data;
        mpw_pkg::REG_COEF_YY_YC: coef_yy_yc <= cfg.data;
        mpw_pkg::REG_COEF_WX_WY: coef_wx_wy <= cfg.data;
        mpw_pkg::REG_COEF_WC: coef_wc <= cfg.data[31:0];
        mpw_pkg::REG_VERTEX_01: vertex_pair_01 <= cfg.data[47:0];
        mpw_pkg::REG_VERTEX_23: vertex_pair_23 <= cfg.data[47:0];
        mpw_pkg::REG_IMAGE_SIZE: image_size <= cfg.data[2*DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_bus.m[0] = coef_xx_xy[31:0];
    cfg_bus.m[1] = coef_xx_xy[63:32];
    cfg_bus.m[2] = coef_xc_yx[31:0];
    cfg_bus.m[3] = coef_xc_yx[63:32];
    cfg_bus.m[4] = coef_yy_yc[31:0];
    cfg_bus.m[5] = coef_yy_yc[63:32];
    cfg_bus.m[6] = coef_wx_wy[31:0];
    cfg_bus.m[7] = coef_wx_wy[63:32];
    cfg_bus.m[8] = coef_wc;
    for (int k = 0; k < NV; k++) begin
      if (k < 2) begin
        cfg_bus.vx[k] = vertex_pair_01[24*(k%2) +: CB];
        cfg_bus.vy[k] = vertex_pair_01[24*(k%2) + 12 +: CB];
      end else begin
        cfg_bus.vx[k] = vertex_pair_23[24*(k%2) +: CB];
        cfg_bus.vy[k] = vertex_pair_23[24*(k%2) + 12 +: CB];
      end
    end
  end

  assign adv = !result.valid || result.ready;
  assign coord.ready = adv;

  mpw_transform u_transform (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(coord.valid),
    .dest_x(coord.dest_x),
    .dest_y(coord.dest_y),
    .cfg(cfg_bus),
    .div_out(chain[0])
  );

  for (genvar s = 0; s < CB; s++) begin : g_div
    mpw_div_step u_step (
      .clk(clk),
      .rst(rst),
      .adv(adv),
      .d_in(chain[s]),
      .d_out(chain[s+1])
    );
  end

  assign we_next = chain[CB].keep &&
                   ({1'b0, chain[CB].q_x} < image_size[DW-1:0]) &&
                   ({1'b0, chain[CB].q_y} < image_size[2*DW-1:DW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= chain[CB].valid;
    end
    if (adv) begin
      result.write_enable <= we_next;
      result.src_x <= we_next ? chain[CB].q_x : '0;
      result.src_y <= we_next ? chain[CB].q_y : '0;
    end
  end

  `ASSERT_IMPLIES(a_zero_when_off, clk, rst, result.valid && !result.write_enable, result.src_x == '0 && result.src_y == '0)
  `ASSERT_IMPLIES(a_in_width, clk, rst, result.valid && result.write_enable, {1'b0, result.src_x} < image_size[DW-1:0])
  `ASSERT_NEXT(a_hold_on_stall, clk, rst, result.valid && !result.ready, $stable(chain[CB].q_x) && $stable(chain[0].valid))
endmodule
